/* src/sop_pkg.sv */
// ----------------------------------------------------------------------------
// sop_pkg
// Shared types and constants for the sandbox offset prefetcher.
// ----------------------------------------------------------------------------
package sop_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STREAM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP   = 3'd4;

  localparam int SC_W     = 16;
  localparam int THR_W    = 12;
  localparam int DCNT_W   = 7;
  localparam logic [SC_W-1:0] SCORE_MAX  = 16'hFFFF;
  localparam logic [4:0]      DEGREE_MAX = 5'd16;

  typedef struct packed {
    logic [4:0] degree;
    logic       sde;
    logic [1:0] slen;
    logic [8:0] phase;
    logic [4:0] swap;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{degree: 5'd4, sde: 1'b1, slen: 2'd3,
                                 phase: 9'd256, swap: 5'd4};

  typedef enum logic [3:0] {
    ST_OLOAD,
    ST_OSORT,
    ST_IDLE,
    ST_PREP,
    ST_SEARCH,
    ST_UPDATE,
    ST_RANK,
    ST_PUSH,
    ST_POP,
    ST_EMIT,
    ST_FLUSH
  } state_t;

endpackage

/* src/sop_front.sv */
// ----------------------------------------------------------------------------
// sop_front
// Input side: takes demand items and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sop_front (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,
  output logic        q_valid,
  output logic [63:0] q_addr,
  input  logic        q_take
);

  logic [63:0] qmem [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  cnt;
  logic        push;

  assign s_tready = (cnt != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (cnt != 2'd0);
  assign q_addr   = qmem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wptr] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_take) rptr <= ~rptr;
      cnt <= cnt + 2'(push) - 2'(q_take);
    end
  end

endmodule

/* src/sop_back.sv */
// ----------------------------------------------------------------------------
// sop_back
// Engine: filter search and insert, scoring, round re-ranking and prefetch walk.
// ----------------------------------------------------------------------------
module sop_back #(
  parameter int N          = 16,
  parameter int DEPTH      = 256,
  parameter int BPP        = 64,
  parameter int BLOCK_BITS = 6,
  parameter int PAGE_BITS  = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  sop_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  logic [63:0]   q_addr,
  output logic          q_take,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [63:0]   m_tdata,
  output logic          m_tuser,
  output logic          m_tlast
);
  import sop_pkg::*;

  localparam int IDX_W  = $clog2(N);
  localparam int CNT_W  = $clog2(N + 1);
  localparam int OFF_W  = $clog2(N) + 2;
  localparam int SP_D   = 2 * N;
  localparam int SP_W   = $clog2(SP_D);
  localparam int SPC_W  = $clog2(SP_D + 1);
  localparam int FA_W   = $clog2(DEPTH);
  localparam int FC_W   = $clog2(DEPTH + 1);
  localparam int PB     = PAGE_BITS - BLOCK_BITS;
  localparam int KEY_W  = 64 - BLOCK_BITS;
  localparam int T_W    = PB + OFF_W + 4;

  state_t state, state_next;

  logic [63:0]             addr;
  logic                    in_item;
  logic signed [OFF_W-1:0] toff [N];
  logic [SC_W-1:0]         tsc [N];
  logic signed [OFF_W-1:0] spare [SP_D];
  logic [SP_W-1:0]         sp_head;
  logic [SPC_W-1:0]        sp_cnt;
  logic [KEY_W-1:0]        fmem [DEPTH];
  logic [KEY_W-1:0]        frd;
  logic                    rd_v;
  logic [FC_W-1:0]         fill;
  logic [FC_W-1:0]         sidx;
  logic [IDX_W-1:0]        ptr;
  logic [8:0]              pcnt;

  logic [KEY_W-1:0]        key0, key_ins;
  logic [KEY_W-1:0]        key_s [3];
  logic [2:0]              sv;
  logic                    ins_ok;
  logic                    h0, hins;
  logic [2:0]              hs;

  logic [CNT_W-1:0]        pass;
  logic [CNT_W-1:0]        si;
  logic [IDX_W-1:0]        ord_idx [N];
  logic [OFF_W:0]          ord_key [N];

  logic [IDX_W-1:0]        pos;
  logic [1:0]              la;
  logic [DCNT_W-1:0]       dcnt;
  logic                    skip;
  logic                    cur_neg;
  logic signed [T_W-1:0]   tacc;
  logic [THR_W-1:0]        thr;

  logic                    pend_v, pend_neg;
  logic [63:0]             pend_addr;
  logic                    out_v, out_neg, out_last;
  logic [63:0]             out_addr;

  // combinational
  logic [IDX_W-1:0]        tr_idx;
  logic [CNT_W-1:0]        push_idx, pop_idx;
  logic signed [OFF_W-1:0] cur_off;
  logic [SC_W-1:0]         cur_sc;
  logic [PB-1:0]           blk;
  logic signed [T_W-1:0]   blk_s, off_t, t_ins;
  logic signed [T_W-1:0]   ts [3];
  logic [KEY_W-1:0]        page_base;
  logic [CNT_W-1:0]        k;
  logic [SP_W-1:0]         sp_tail;
  logic [SPC_W:0]          tail_sum;
  logic [2:0]              nhit;
  logic [SC_W:0]           sc_sum;
  logic [8:0]              pcnt_n;
  logic                    phase_end;
  logic                    mem_we, mem_re;
  logic signed [OFF_W-1:0] r_off [N];
  logic [SC_W-1:0]         r_sc [N];
  logic [IDX_W-1:0]        o_idx [N];
  logic [OFF_W:0]          o_key [N];
  logic                    e_neg, newdir, eff_skip, em_hit, entry_done, e_adv, stall;
  logic [DCNT_W-1:0]       eff_cnt, cnt_n;
  logic signed [T_W-1:0]   tcur;
  logic [THR_W-1:0]        thrcur;
  logic [1:0]              lamax;
  logic [4:0]              pd;
  logic                    slot_free, load_o;
  logic [63:0]             paddr;

  function automatic logic in_page(input logic signed [T_W-1:0] t);
    in_page = !t[T_W-1] && (t < T_W'(BPP));
  endfunction

  function automatic logic [KEY_W-1:0] blk_key(input logic [KEY_W-1:0] base,
                                               input logic signed [T_W-1:0] t);
    blk_key = base + {{(KEY_W-T_W){1'b0}}, t};
  endfunction

  // ---------------------------------------------------------------- shared read
  assign push_idx = CNT_W'(N - 1) - si;
  assign pop_idx  = CNT_W'(N) - k + si;

  always_comb begin
    case (state)
      ST_EMIT: tr_idx = ord_idx[pos];
      ST_PUSH: tr_idx = push_idx[IDX_W-1:0];
      default: tr_idx = ptr;
    endcase
  end

  assign cur_off   = toff[tr_idx];
  assign cur_sc    = tsc[tr_idx];
  assign blk       = addr[PAGE_BITS-1:BLOCK_BITS];
  assign blk_s     = $signed({{(T_W-PB){1'b0}}, blk});
  assign off_t     = $signed({{(T_W-OFF_W){cur_off[OFF_W-1]}}, cur_off});
  assign page_base = {addr[63:PAGE_BITS], {PB{1'b0}}};
  assign t_ins     = blk_s + off_t;
  assign ts[0]     = blk_s - off_t;
  assign ts[1]     = blk_s - (off_t <<< 1);
  assign ts[2]     = ts[1] - off_t;

  assign k = ({1'b0, cfg.swap} > 6'(N)) ? CNT_W'(N) : CNT_W'(cfg.swap);
  assign tail_sum = {1'b0, {(SPC_W-SP_W){1'b0}}, sp_head} + {1'b0, sp_cnt};
  assign sp_tail  = (tail_sum >= (SPC_W+1)'(SP_D)) ? SP_W'(tail_sum - (SPC_W+1)'(SP_D))
                                                    : SP_W'(tail_sum);

  assign nhit = 3'(h0) + 3'(h0 & sv[0] & hs[0]) + 3'(h0 & sv[1] & hs[1])
              + 3'(h0 & sv[2] & hs[2]);
  assign sc_sum    = {1'b0, cur_sc} + (SC_W+1)'(nhit);
  assign pcnt_n    = pcnt + 9'd1;
  assign phase_end = (pcnt_n == cfg.phase);

  // ---------------------------------------------------------------- sort passes
  // odd-even transposition, swap only when strictly out of order (stable)
  always_comb begin
    r_off = toff;
    r_sc  = tsc;
    o_idx = ord_idx;
    o_key = ord_key;
    for (int j = 0; j < N - 1; j++) begin
      if (((j % 2) == 1) == pass[0]) begin
        if (tsc[j] < tsc[j+1]) begin
          r_off[j]   = toff[j+1];
          r_off[j+1] = toff[j];
          r_sc[j]    = tsc[j+1];
          r_sc[j+1]  = tsc[j];
        end
        if (ord_key[j] > ord_key[j+1]) begin
          o_idx[j]   = ord_idx[j+1];
          o_idx[j+1] = ord_idx[j];
          o_key[j]   = ord_key[j+1];
          o_key[j+1] = ord_key[j];
        end
      end
    end
  end

  // ---------------------------------------------------------------- emit step
  assign slot_free  = !out_v || m_tready;
  assign e_neg      = ord_key[pos][OFF_W];
  assign newdir     = e_neg && !cur_neg;
  assign eff_skip   = newdir ? 1'b0 : skip;
  assign eff_cnt    = newdir ? '0 : dcnt;
  assign tcur       = (la == 2'd0) ? blk_s + off_t : tacc;
  assign thrcur     = (la == 2'd0) ? THR_W'(cfg.phase) : thr;
  assign em_hit     = !eff_skip && (cur_sc >= SC_W'(thrcur)) && in_page(tcur);
  assign lamax      = cfg.sde ? cfg.slen : 2'd0;
  assign entry_done = (la == lamax);
  assign cnt_n      = eff_cnt + DCNT_W'(em_hit);
  assign pd         = (cfg.degree > DEGREE_MAX) ? DEGREE_MAX : cfg.degree;
  assign stall      = em_hit && pend_v && !slot_free;
  assign e_adv      = eff_skip || entry_done;
  assign paddr      = {addr[63:PAGE_BITS], {PAGE_BITS{1'b0}}}
                    + ({{(64-T_W){1'b0}}, tcur} << BLOCK_BITS);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      ST_OLOAD:  state_next = ST_OSORT;
      ST_OSORT:  if (pass == CNT_W'(N - 1)) state_next = in_item ? ST_EMIT : ST_IDLE;
      ST_IDLE:   if (q_valid) state_next = ST_PREP;
      ST_PREP:   state_next = ST_SEARCH;
      ST_SEARCH: if (sidx >= fill) state_next = ST_UPDATE;
      ST_UPDATE: state_next = (phase_end && ptr == IDX_W'(N - 1)) ? ST_RANK : ST_EMIT;
      ST_RANK:   if (pass == CNT_W'(N - 1)) state_next = (k != '0) ? ST_PUSH : ST_OLOAD;
      ST_PUSH:   if (si == k - CNT_W'(1)) state_next = ST_POP;
      ST_POP:    if (si == k - CNT_W'(1)) state_next = ST_OLOAD;
      ST_EMIT:   if (!stall && e_adv && pos == IDX_W'(N - 1)) state_next = ST_FLUSH;
      ST_FLUSH:  if (!pend_v || slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control outputs
  always_comb begin
    q_take = (state == ST_IDLE) && q_valid;
    mem_re = (state == ST_SEARCH) && (sidx < fill);
    mem_we = (state == ST_UPDATE) && ins_ok && !hins && (fill < FC_W'(DEPTH));
    load_o = ((state == ST_EMIT) && em_hit && pend_v && slot_free)
          || ((state == ST_FLUSH) && pend_v && slot_free);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_OLOAD;
    else     state <= state_next;
  end

  // ---------------------------------------------------------------- filter memory
  always_ff @(posedge clk) begin
    if (mem_we) fmem[fill[FA_W-1:0]] <= key_ins;
    if (mem_re) frd <= fmem[sidx[FA_W-1:0]];
  end

  // ---------------------------------------------------------------- item datapath
  always_ff @(posedge clk) begin
    if (q_take) addr <= q_addr;
    if (state == ST_PREP) begin
      key0    <= addr[63:BLOCK_BITS];
      key_ins <= blk_key(page_base, t_ins);
      ins_ok  <= in_page(t_ins);
      for (int i = 0; i < 3; i++) begin
        key_s[i] <= blk_key(page_base, ts[i]);
        sv[i]    <= cfg.sde && (cfg.slen > 2'(i)) && in_page(ts[i]);
      end
      h0   <= 1'b0;
      hs   <= '0;
      hins <= 1'b0;
    end else if (rd_v) begin
      if (frd == key0) h0 <= 1'b1;
      if (frd == key_ins) hins <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (frd == key_s[i]) hs[i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && !stall) begin
      if (!e_adv) begin
        tacc <= tcur + off_t;
        thr  <= thrcur + THR_W'(cfg.phase);
      end
    end
    if (state == ST_EMIT && em_hit && !stall) begin
      pend_addr <= paddr;
      pend_neg  <= e_neg;
    end
    if (load_o) begin
      out_addr <= pend_addr;
      out_neg  <= pend_neg;
      out_last <= (state == ST_FLUSH);
    end
  end

  // ---------------------------------------------------------------- control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        toff[i] <= (i < N / 2) ? OFF_W'(i + 1) : OFF_W'(i - N);
        tsc[i]  <= '0;
      end
      for (int i = 0; i < SP_D; i++) begin
        if (i < N / 2)  spare[i] <= OFF_W'(N / 2 + 1 + i);
        else if (i < N) spare[i] <= OFF_W'(i - N - N / 2);
        else            spare[i] <= '0;
      end
      sp_head <= '0;
      sp_cnt  <= SPC_W'(N);
      fill    <= '0;
      sidx    <= '0;
      rd_v    <= 1'b0;
      ptr     <= '0;
      pcnt    <= '0;
      pass    <= '0;
      si      <= '0;
      pos     <= '0;
      la      <= '0;
      dcnt    <= '0;
      skip    <= 1'b0;
      cur_neg <= 1'b0;
      pend_v  <= 1'b0;
      out_v   <= 1'b0;
      in_item <= 1'b0;
    end else begin
      if (load_o)        out_v <= 1'b1;
      else if (m_tready) out_v <= 1'b0;

      if (state == ST_IDLE) in_item <= 1'b0;
      if (state == ST_PREP) in_item <= 1'b1;

      if (state == ST_SEARCH) begin
        rd_v <= mem_re;
        if (mem_re) sidx <= sidx + FC_W'(1);
      end else begin
        rd_v <= 1'b0;
        sidx <= '0;
      end

      if (state == ST_UPDATE) begin
        tsc[ptr] <= sc_sum[SC_W] ? SCORE_MAX : sc_sum[SC_W-1:0];
        if (phase_end) begin
          fill <= '0;
          pcnt <= '0;
          ptr  <= (ptr == IDX_W'(N - 1)) ? '0 : ptr + IDX_W'(1);
        end else begin
          pcnt <= pcnt_n;
          if (mem_we) fill <= fill + FC_W'(1);
        end
      end

      if (state == ST_RANK || state == ST_OSORT) pass <= pass + CNT_W'(1);
      else                                         pass <= '0;

      if (state == ST_RANK) begin
        toff <= r_off;
        tsc  <= r_sc;
      end
      if (state == ST_OSORT) begin
        ord_idx <= o_idx;
        ord_key <= o_key;
      end
      if (state == ST_OLOAD) begin
        for (int j = 0; j < N; j++) begin
          ord_idx[j] <= IDX_W'(j);
          ord_key[j] <= {toff[j] <= 0, toff[j][OFF_W-1] ? OFF_W'(-toff[j]) : OFF_W'(toff[j])};
        end
      end

      if (state == ST_PUSH || state == ST_POP) begin
        si <= (si == k - CNT_W'(1)) ? '0 : si + CNT_W'(1);
      end else begin
        si <= '0;
      end
      if (state == ST_PUSH) begin
        spare[sp_tail] <= cur_off;
        sp_cnt         <= sp_cnt + SPC_W'(1);
      end
      if (state == ST_POP) begin
        toff[pop_idx[IDX_W-1:0]] <= spare[sp_head];
        tsc[pop_idx[IDX_W-1:0]]  <= '0;
        sp_head <= (sp_head == SP_W'(SP_D - 1)) ? '0 : sp_head + SP_W'(1);
        sp_cnt  <= sp_cnt - SPC_W'(1);
      end

      if (state == ST_EMIT) begin
        if (!stall) begin
          cur_neg <= e_neg;
          dcnt    <= cnt_n;
          if (em_hit) pend_v <= 1'b1;
          if (e_adv) begin
            la   <= '0;
            pos  <= pos + IDX_W'(1);
            skip <= eff_skip || (cnt_n > DCNT_W'(pd));
          end else begin
            la   <= la + 2'd1;
            skip <= 1'b0;
          end
        end
      end else begin
        pos     <= '0;
        la      <= '0;
        dcnt    <= '0;
        skip    <= 1'b0;
        cur_neg <= 1'b0;
      end
      if (state == ST_FLUSH && load_o) pend_v <= 1'b0;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_addr;
  assign m_tuser  = out_neg;
  assign m_tlast  = out_last;

endmodule

/* src/sandbox_offset_prefetcher.sv */
// ----------------------------------------------------------------------------
// sandbox_offset_prefetcher
// Offset prefetcher that scores trial offsets against a filter of pseudo
// prefetches and issues in-page prefetches from the best scoring offsets.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one demand byte address per item. m_* returns the prefetch
//   addresses it causes, positive offsets first; m_tuser flags a negative
//   offset, m_tlast marks the final prefetch of a demand. A demand that
//   causes no prefetch returns nothing.
//   cfg_we/cfg_index/cfg_data write the five control registers; write only
//   while no demand is in flight.
// Timing:
//   Items are handled one at a time: a filter search over the filter fill
//   (one filter entry read per cycle from the single-port filter RAM), then
//   up to TRIAL_OFFSETS * (stream_length + 1) walk steps, one offset step per
//   cycle while the output does not stall. A round end adds two sort sweeps,
//   a reload step and the spare queue exchange.
//   A two-entry input queue lets demands arrive while the engine works.
// Reset: the offset order is loaded and sorted first; input items are
//   queued meanwhile. A stalled m_tready holds the walk when a further
//   prefetch is ready while the output and pending registers are full.
// ----------------------------------------------------------------------------
module sandbox_offset_prefetcher #(
  parameter int TRIAL_OFFSETS   = 16,
  parameter int FILTER_DEPTH    = 256,
  parameter int BLOCKS_PER_PAGE = 64,
  parameter int BLOCK_BITS      = 6,
  parameter int PAGE_BITS       = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [63:0]                     s_tdata,   // [63:0] demand_address
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [63:0]                     m_tdata,   // [63:0] prefetch_address
  output logic                            m_tuser,   // [0] from_negative
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [sop_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sop_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sop_pkg::*;

  cfg_t        cfg;
  logic        q_valid;
  logic [63:0] q_addr;
  logic        q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEGREE: cfg.degree <= cfg_data[4:0];
        REG_STREAM: cfg.sde    <= cfg_data[0];
        REG_SLEN:   cfg.slen   <= cfg_data[1:0];
        REG_PHASE:  cfg.phase  <= cfg_data[8:0];
        REG_SWAP:   cfg.swap   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  sop_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_addr   (q_addr),
    .q_take   (q_take)
  );

  sop_back #(
    .N          (TRIAL_OFFSETS),
    .DEPTH      (FILTER_DEPTH),
    .BPP        (BLOCKS_PER_PAGE),
    .BLOCK_BITS (BLOCK_BITS),
    .PAGE_BITS  (PAGE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_addr   (q_addr),
    .q_take   (q_take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* src/sop_checker.sv */
// ----------------------------------------------------------------------------
// sop_checker
// Port-level checks on the prefetch output stream.
// ----------------------------------------------------------------------------
module sop_checker #(
  parameter int BLOCK_BITS = 6
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("output item changed while stalled");

  // prefetches are block aligned
  a_align: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[BLOCK_BITS-1:0] == '0)
    else $error("prefetch address not block aligned");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // negative offsets follow positive ones within a demand
  a_dir: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser && !m_tlast
      |=> !(m_tvalid && !m_tuser))
    else $error("positive prefetch after a negative one in the same demand");

endmodule

bind sandbox_offset_prefetcher sop_checker #(.BLOCK_BITS(BLOCK_BITS)) u_sop_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

/* tb/sandbox_offset_prefetcher_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sandbox_offset_prefetcher_checker
// Watches the demand, prefetch and register channels. It keeps its own copy of
// the offset table, spare queue and filter, works out the prefetches that each
// accepted demand causes, and compares them in order with the prefetch stream.
// ----------------------------------------------------------------------------
module sandbox_offset_prefetcher_checker
  import sop_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [63:0]          s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [63:0]          m_tdata,
  input  logic                 m_tuser,
  input  logic                 m_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                   fails,
  output int                   pending
);

  localparam int NOFS = 16;
  localparam int NSPARE = 32;
  localparam int NFILT = 256;

  typedef struct {
    logic [63:0] addr;
    bit          neg;
    bit          last;
  } prefetch_t;

  prefetch_t prefetch_q[$];

  int          ofs_val[NOFS];
  int unsigned ofs_score[NOFS];
  int          spare_val[NSPARE];
  int unsigned spare_head, spare_cnt;
  logic [57:0] filt[NFILT];
  int unsigned filt_fill, trial_ptr, phase_cnt;

  int unsigned degree, stream_on, stream_len, phase_len, swap_cnt;

  function automatic void clear_model();
    for (int i = 0; i < NOFS; i++) begin
      ofs_val[i] = i < NOFS / 2 ? i + 1 : i - NOFS;
      ofs_score[i] = 0;
      spare_val[i] = i < NOFS / 2 ? NOFS / 2 + 1 + i : i - NOFS - NOFS / 2;
      spare_val[i + NOFS] = 0;
    end
    spare_head = 0;
    spare_cnt = NOFS;
    filt_fill = 0;
    trial_ptr = 0;
    phase_cnt = 0;
    degree = 4;
    stream_on = 1;
    stream_len = 3;
    phase_len = 256;
    swap_cnt = 4;
  endfunction

  function automatic bit filt_has(logic [57:0] b);
    for (int unsigned i = 0; i < filt_fill; i++)
      if (filt[i] == b) return 1;
    return 0;
  endfunction

  function automatic void bump(int p);
    if (ofs_score[p] < SCORE_MAX) ofs_score[p]++;
  endfunction

  function automatic int mag(int v);
    return v < 0 ? -v : v;
  endfunction

  // stable sort by descending score, then trade the weakest for spares
  function automatic void swap_weakest();
    int unsigned k;
    int j, o;
    int unsigned s;
    k = swap_cnt > NOFS ? NOFS : swap_cnt;
    for (int i = 1; i < NOFS; i++) begin
      o = ofs_val[i];
      s = ofs_score[i];
      j = i;
      while (j > 0 && ofs_score[j-1] < s) begin
        ofs_val[j] = ofs_val[j-1];
        ofs_score[j] = ofs_score[j-1];
        j--;
      end
      ofs_val[j] = o;
      ofs_score[j] = s;
    end
    for (int unsigned i = 0; i < k; i++) begin
      spare_val[(spare_head + spare_cnt) % NSPARE] = ofs_val[NOFS - 1 - i];
      spare_cnt++;
    end
    for (int unsigned i = 0; i < k; i++) begin
      ofs_val[NOFS - k + i] = spare_val[spare_head];
      ofs_score[NOFS - k + i] = 0;
      spare_head = (spare_head + 1) % NSPARE;
      spare_cnt--;
    end
  endfunction

  function automatic void walk(bit neg, logic [51:0] pg, int blk);
    int lst[NOFS];
    int len, j, e, t, off;
    int unsigned cnt, pd, sc;
    prefetch_t pf;
    len = 0;
    cnt = 0;
    pd = degree > DEGREE_MAX ? DEGREE_MAX : degree;
    for (int i = 0; i < NOFS; i++)
      if ((ofs_val[i] <= 0) == neg) begin
        lst[len] = i;
        len++;
      end
    // nearest offsets first, stable
    for (int i = 1; i < len; i++) begin
      e = lst[i];
      j = i;
      while (j > 0 && mag(ofs_val[lst[j-1]]) > mag(ofs_val[e])) begin
        lst[j] = lst[j-1];
        j--;
      end
      lst[j] = e;
    end
    for (int i = 0; i < len; i++) begin
      off = ofs_val[lst[i]];
      sc = ofs_score[lst[i]];
      for (int la = 1; la <= stream_len + 1; la++) begin
        if (la > 1 && stream_on == 0) break;
        if (sc < la * phase_len) continue;
        t = blk + off * la;
        if (t >= 0 && t < 64) begin
          pf.addr = {pg, t[5:0], 6'b0};
          pf.neg = neg;
          pf.last = 0;
          prefetch_q = {prefetch_q, pf};
          cnt++;
        end
      end
      if (cnt > pd) break;
    end
  endfunction

  function automatic void predict_prefetches(logic [63:0] a);
    logic [51:0] pg;
    int blk, p, off, t;
    int unsigned n0;
    pg = a[63:12];
    blk = int'(a[11:6]);
    p = trial_ptr % NOFS;
    off = ofs_val[p];
    phase_cnt = (phase_cnt + 1) & 9'h1FF;
    if (filt_has(a[63:6])) begin
      bump(p);
      if (stream_on != 0)
        for (int i = 1; i <= stream_len; i++) begin
          t = blk - off * i;
          if (t >= 0 && t < 64 && filt_has({pg, t[5:0]})) bump(p);
        end
    end
    t = blk + off;
    if (t >= 0 && t < 64 && !filt_has({pg, t[5:0]}) && filt_fill < NFILT) begin
      filt[filt_fill] = {pg, t[5:0]};
      filt_fill++;
    end
    if (phase_cnt == phase_len) begin
      filt_fill = 0;
      phase_cnt = 0;
      if (p + 1 < NOFS) trial_ptr = p + 1;
      else begin
        swap_weakest();
        trial_ptr = 0;
      end
    end
    n0 = prefetch_q.size();
    walk(0, pg, blk);
    walk(1, pg, blk);
    if (prefetch_q.size() > n0) prefetch_q[prefetch_q.size()-1].last = 1;
  endfunction

  always @(posedge clk) begin
    prefetch_t e;
    if (rst) begin
      clear_model();
      prefetch_q.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEGREE: degree = cfg_data[4:0];
          REG_STREAM: stream_on = cfg_data[0];
          REG_SLEN:   stream_len = cfg_data[1:0];
          REG_PHASE:  phase_len = cfg_data[8:0];
          REG_SWAP:   swap_cnt = cfg_data[4:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_prefetches(s_tdata);
      if (m_tvalid && m_tready) begin
        if (prefetch_q.size() == 0) begin
          $display("%0t: unexpected prefetch exp=none got addr=%h neg=%b last=%b",
                   $time, m_tdata, m_tuser, m_tlast);
          fails++;
        end else begin
          e = prefetch_q[0];
          prefetch_q.delete(0);
          if (m_tdata !== e.addr) begin
            $display("%0t: addr mismatch exp=%h got=%h", $time, e.addr, m_tdata);
            fails++;
          end
          if (m_tuser !== e.neg) begin
            $display("%0t: neg flag mismatch exp=%b got=%b", $time, e.neg, m_tuser);
            fails++;
          end
          if (m_tlast !== e.last) begin
            $display("%0t: last mismatch exp=%b got=%b", $time, e.last, m_tlast);
            fails++;
          end
        end
      end
    end
    pending = prefetch_q.size();
  end

endmodule

/* tb/sandbox_offset_prefetcher_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sandbox_offset_prefetcher_tb
// Drives demand addresses through several register settings, mostly strided
// runs inside a few pages mixed with random addresses, with random stalls on
// both channels. The checker predicts and compares every prefetch.
// ----------------------------------------------------------------------------
module sandbox_offset_prefetcher_tb;
  import sop_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [63:0]           s_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [63:0]           m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fails;
  int                    pending;

  bit          quiet;
  int          stall_left = 0;
  logic [51:0] pages[8];
  logic [51:0] cur_page;
  int          cur_blk, stride, run_left;

  sandbox_offset_prefetcher dut (.*);

  sandbox_offset_prefetcher_checker chk (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    #40_000_000;
    $display("sandbox_offset_prefetcher_tb: FAIL");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 16);
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v[CFG_DATA_W-1:0];
  endtask

  task automatic set_regs(int unsigned deg, int unsigned sde, int unsigned slen,
                          int unsigned phase, int unsigned swp);
    write_reg(REG_DEGREE, deg);
    write_reg(REG_STREAM, sde);
    write_reg(REG_SLEN, slen);
    write_reg(REG_PHASE, phase);
    write_reg(REG_SWAP, swp);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // leaves s_tvalid high so back-to-back items keep it up
  task automatic send_demand(logic [63:0] a);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = a;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    // demands that cause nothing may still be in the engine
    repeat (1500) @(posedge clk);
  endtask

  function automatic logic [63:0] next_demand();
    logic [63:0] a;
    a = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) return a;
    if (run_left == 0 || cur_blk + stride < 0 || cur_blk + stride > 63) begin
      cur_page = pages[$urandom_range(0, 7)];
      cur_blk = $urandom_range(0, 63);
      stride = $urandom_range(0, 1) ? $urandom_range(1, 9) : -$urandom_range(1, 9);
      run_left = $urandom_range(4, 24);
    end else begin
      cur_blk += stride;
      run_left--;
    end
    return {cur_page, cur_blk[5:0], a[5:0]};
  endfunction

  task automatic random_demands(int n);
    repeat (n) send_demand(next_demand());
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 0;
    run_left = 0;
    cur_blk = 0;
    stride = 1;
    for (int i = 0; i < 8; i++) pages[i] = {$urandom, $urandom};
    pages[0] = '0;
    pages[1] = '1;
    cur_page = pages[0];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    drain();

    // directed: extremes, unaligned bytes, page edges, both stride signs
    set_regs(16, 1, 3, 2, 4);
    send_demand(64'h0);
    send_demand(64'hFFFF_FFFF_FFFF_FFFF);
    send_demand(64'h0000_0000_0000_0FC0);
    send_demand(64'hFFFF_FFFF_FFFF_F03F);
    for (int b = 0; b < 10; b++) send_demand({52'h12345, 6'(b), 6'(b * 5)});
    for (int b = 63; b > 55; b--) send_demand({52'hABCDE, 6'(b), 6'h3F});
    send_demand(64'hFFFF_FFFF_FFFF_F000);
    send_demand(64'h0000_0000_0000_003F);
    @(negedge clk);
    s_tvalid = 1'b0;
    drain();

    set_regs(0, 0, 0, 1, 16);
    random_demands(30);
    drain();
    set_regs(31, 1, 2, 3, 31);
    random_demands(50);
    drain();
    // phase length zero: one long phase
    set_regs(4, 1, 3, 0, 0);
    random_demands(184);
    drain();
    set_regs(16, 1, 1, 511, 8);
    random_demands(12);
    drain();
    set_regs(7, 1, 3, 256, 5);
    random_demands(10);
    drain();
    set_regs(5, 1, 3, 4, 3);
    random_demands(30);
    drain();
    quiet = 1;
    set_regs(16, 1, 3, 2, 4);
    random_demands(40);
    drain();

    if (fails == 0) begin
      $display("sandbox_offset_prefetcher_tb: PASS");
    end else begin
      $display("sandbox_offset_prefetcher_tb: FAIL");
    end
    $finish;
  end

endmodule
